// File: sv/mkh_pkg.sv
// Package for the masked k-mer histogram: sizes, action codes, base decode.
// Used by every module of the block but mkh_ram; depends on nothing.
package mkh_pkg;
	localparam int MaxK = 10;
	localparam int CountBits = 40;
	localparam int IdxW = 20;
	localparam int KW = 4;
	localparam int SeenW = 4;
	localparam logic [3:0] SeenCap = 4'd15;
	localparam logic [KW-1:0] KReset = 4'd3;

	localparam logic [1:0] KmerLenAddr = 2'd0;

	localparam logic [1:0] ActPush = 2'd0;
	localparam logic [1:0] ActRestart = 2'd1;
	localparam logic [1:0] ActRead = 2'd2;

	typedef struct packed {
		logic restart;
		logic push;
		logic lookup;
		logic commit;
		logic clr_step;
	} mkh_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic lookup_valid;
	} mkh_stat_t;

	function automatic logic [2:0] base_decode(input logic [7:0] c);
		logic [2:0] r;
		case (c)
			8'h41, 8'h61: r = 3'b100;
			8'h43, 8'h63: r = 3'b101;
			8'h47, 8'h67: r = 3'b110;
			8'h54, 8'h74: r = 3'b111;
			default: r = 3'b000;
		endcase
		return r;
	endfunction
endpackage

// File: sv/mkh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mkh_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: sv/mkh_datapath.sv
// Datapath: window registers, totals, count store and its clearing sweep.
// Depends on mkh_pkg and mkh_ram.
module mkh_datapath #(
	parameter int MAX_K = mkh_pkg::MaxK,
	parameter int COUNT_BITS = mkh_pkg::CountBits
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mkh_pkg::mkh_cmd_t            cmd,
	input  logic [7:0]                   base_char,
	input  logic                         masked,
	input  logic [mkh_pkg::IdxW-1:0]     query_index,
	input  logic [mkh_pkg::KW-1:0]       kmer_length,
	output mkh_pkg::mkh_stat_t           stat,
	output logic [COUNT_BITS-1:0]        kmer_count,
	output logic [COUNT_BITS-1:0]        valid_total,
	output logic [COUNT_BITS-1:0]        masked_total,
	output logic [COUNT_BITS-1:0]        invalid_total
);
	import mkh_pkg::*;

	localparam int AW = 2 * MAX_K;
	localparam int Depth = 1 << AW;
	localparam logic [COUNT_BITS-1:0] CMax = '1;

	logic [AW-1:0] window_q, clr_addr_q, addr_s1;
	logic [MAX_K-1:0] mask_q;
	logic [SeenW-1:0] seen_q, since_q;
	logic [COUNT_BITS-1:0] valid_q, masked_q, invalid_q, rdata;
	logic upd_s1, clr_done_q;
	logic [KW-1:0] k;
	logic [2:0] dec;
	logic [AW-1:0] win_next, code_mask, qaddr;
	logic [MAX_K-1:0] mask_next;
	logic [SeenW-1:0] seen_next, since_next;
	logic complete, is_masked, is_invalid;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [COUNT_BITS-1:0] wdata;

	always_comb begin
		if (kmer_length == '0) begin
			k = KW'(1);
		end else if (kmer_length > KW'(MAX_K)) begin
			k = KW'(MAX_K);
		end else begin
			k = kmer_length;
		end
		dec = base_decode(base_char);
		qaddr = AW'(query_index);
		code_mask = AW'(({(AW+1){1'b0}} | ((AW+1)'(1) << (2 * k))) - (AW+1)'(1));
		win_next = AW'({window_q, dec[1:0]}) & code_mask;
		mask_next = MAX_K'({mask_q, masked});
		seen_next = (seen_q < SeenCap) ? seen_q + 1'b1 : seen_q;
		since_next = !dec[2] ? '0 : ((since_q < SeenCap) ? since_q + 1'b1 : since_q);
		complete = seen_next >= SeenW'(k);
		is_masked = mask_next[k - 1'b1];
		is_invalid = since_next < SeenW'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			mask_q <= '0;
			seen_q <= '0;
			since_q <= '0;
			valid_q <= '0;
			masked_q <= '0;
			invalid_q <= '0;
			upd_s1 <= 1'b0;
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else begin
			upd_s1 <= 1'b0;
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.restart) begin
				window_q <= '0;
				mask_q <= '0;
				seen_q <= '0;
				since_q <= '0;
			end else if (cmd.push) begin
				window_q <= win_next;
				mask_q <= mask_next;
				seen_q <= seen_next;
				since_q <= since_next;
				if (complete) begin
					if (is_masked) begin
						masked_q <= (masked_q == CMax) ? masked_q : masked_q + 1'b1;
					end else if (is_invalid) begin
						invalid_q <= (invalid_q == CMax) ? invalid_q : invalid_q + 1'b1;
					end else begin
						valid_q <= (valid_q == CMax) ? valid_q : valid_q + 1'b1;
						upd_s1 <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.lookup) begin
			addr_s1 <= cmd.push ? win_next : qaddr;
		end
	end

	// A counted window reads its entry, then the controller commits the increment.
	always_comb begin
		raddr = cmd.push ? win_next : qaddr;
		we = cmd.clr_step || cmd.commit;
		waddr = cmd.clr_step ? clr_addr_q : addr_s1;
		wdata = cmd.clr_step ? '0 : ((rdata == CMax) ? rdata : rdata + 1'b1);
	end

	mkh_ram #(.Width(COUNT_BITS), .Depth(Depth)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(cmd.push || cmd.lookup), .raddr(raddr), .rdata(rdata)
	);

	assign stat.clr_done = clr_done_q;
	assign stat.lookup_valid = upd_s1;
	assign kmer_count = rdata;
	assign valid_total = valid_q;
	assign masked_total = masked_q;
	assign invalid_total = invalid_q;
endmodule

// File: sv/mkh_ctrl.sv
// Controller: clearing sweep, item sequencing and the output word load and handshake.
// Depends on mkh_pkg.
module mkh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         action,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mkh_pkg::mkh_stat_t stat,
	output mkh_pkg::mkh_cmd_t  cmd,
	output logic               load_out
);
	import mkh_pkg::*;

	localparam logic [2:0] StClear = 3'd0;
	localparam logic [2:0] StIdle = 3'd1;
	localparam logic [2:0] StCommit = 3'd2;
	localparam logic [2:0] StRead = 3'd3;
	localparam logic [2:0] StOut = 3'd4;

	logic [2:0] state_q, state_d;
	logic take;

	always_comb begin
		in_ready = (state_q == StIdle);
		take = in_valid && in_ready;
		cmd = '0;
		cmd.clr_step = (state_q == StClear) && !stat.clr_done;
		cmd.push = take && (action == ActPush);
		cmd.restart = take && (action == ActRestart);
		cmd.lookup = take && (action == ActRead);
		cmd.commit = (state_q == StCommit) && stat.lookup_valid;
		load_out = (state_q == StRead);
		out_valid = (state_q == StOut);
		state_d = state_q;
		case (state_q)
			StClear: if (stat.clr_done) state_d = StIdle;
			StIdle: begin
				if (cmd.push) state_d = StCommit;
				else if (cmd.lookup) state_d = StRead;
			end
			StCommit: state_d = StIdle;
			StRead: state_d = StOut;
			StOut: if (out_ready) state_d = StIdle;
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StClear;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: sv/masked_kmer_histogram.sv
// Masked k-mer histogram top level. A push reads the store, then writes the count back.
// A restart clears the window state; a read loads its output word, which is held until taken.
// A new base is not taken until the previous push has finished its commit step.
// After reset all 4^MAX_K store entries are swept to zero before any word is accepted.
// Depends on mkh_pkg, mkh_ctrl, mkh_datapath and mkh_ram.
module masked_kmer_histogram #(
	parameter int MAX_K = mkh_pkg::MaxK,
	parameter int COUNT_BITS = mkh_pkg::CountBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata, // action, base_char, masked, query_index, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [8*((mkh_pkg::IdxW+4*COUNT_BITS+7)/8)-1:0] m_tdata, // read_index, kmer_count, valid_total, masked_total, invalid_total, zero pad
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import mkh_pkg::*;

	localparam int OW = 8 * ((IdxW + 4 * COUNT_BITS + 7) / 8);

	mkh_cmd_t cmd;
	mkh_stat_t stat;
	logic load_out;
	logic [KW-1:0] klen_q;
	logic [IdxW-1:0] qidx_q;
	logic [COUNT_BITS-1:0] kc, vt, mt, it;
	logic [OW-1:0] out_q;

	assign pready = 1'b1;
	assign prdata = (paddr == KmerLenAddr) ? {28'd0, klen_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KReset;
		end else if (psel && penable && pwrite && paddr == KmerLenAddr) begin
			klen_q <= pwdata[KW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			qidx_q <= s_tdata[11 +: IdxW];
		end
		if (load_out) begin
			out_q <= OW'({it, mt, vt, kc, qidx_q});
		end
	end

	mkh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .action(s_tdata[1:0]),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
		.stat(stat), .cmd(cmd), .load_out(load_out)
	);

	mkh_datapath #(.MAX_K(MAX_K), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .base_char(s_tdata[9:2]),
		.masked(s_tdata[10]), .query_index(s_tdata[11 +: IdxW]), .kmer_length(klen_q),
		.stat(stat), .kmer_count(kc), .valid_total(vt), .masked_total(mt),
		.invalid_total(it)
	);

	assign m_tdata = out_q;
endmodule

// File: sv/mkh_checker.sv
// Port-level checker for the masked k-mer histogram, bound to the top level.
// Depends on mkh_pkg and masked_kmer_histogram's ports only.
module mkh_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [31:0]  s_tdata,
	input logic         m_tvalid,
	input logic         m_tready
);
	import mkh_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == ActRead |=> ##1 m_tvalid)
		else $error("read gave no word");
	a_push_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] != ActRead |=> !m_tvalid)
		else $error("word without a read");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while word pending");
endmodule

bind masked_kmer_histogram mkh_checker u_mkh_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
);
